@@ rtl/core/mfp_pkg.sv @@
// shared types and constants for the midi file event parser
// used by mfp_parser, mfp_timediv and midi_file_event_parser
package mfp_pkg;

  localparam int unsigned MaxVlqBytesDefault = 4;

  localparam logic [31:0] MagicHdr   = 32'h4D546864;
  localparam logic [31:0] MagicTrk   = 32'h4D54726B;
  localparam logic [23:0] TempoReset = 24'd697674;
  localparam logic [15:0] TpqReset   = 16'h00F0;
  localparam logic [7:0]  MetaEot    = 8'h2F;
  localparam logic [7:0]  MetaTempo  = 8'h51;
  localparam logic [31:0] HdrLen     = 32'd6;
  localparam int unsigned ProdW      = 52;
  localparam int unsigned TpqW       = 16;

  typedef enum logic [2:0] {
    KIND_TIME  = 3'd0,
    KIND_TRST  = 3'd1,
    KIND_NOTE  = 3'd2,
    KIND_TDONE = 3'd3,
    KIND_FDONE = 3'd4,
    KIND_ERROR = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ERR_HDR_MAGIC = 4'd0,
    ERR_HDR_LEN   = 4'd1,
    ERR_TRK_MAGIC = 4'd2,
    ERR_VLQ       = 4'd3,
    ERR_NO_RS     = 4'd4,
    ERR_ARG_BIT7  = 4'd5,
    ERR_META      = 4'd6,
    ERR_SYS       = 4'd7,
    ERR_TRK_LEN   = 4'd8,
    ERR_DIVISION  = 4'd9
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  channel;
    logic [6:0]  key;
    logic [6:0]  velocity;
    logic        note_on;
    logic [30:0] time_amount;
    err_e        error_code;
    logic        last_track;
  } result_t;

  // command from parser to the time divider
  typedef struct packed {
    logic        start;
    logic [27:0] ticks;
    logic [23:0] tempo;
    logic [15:0] tpq;
  } div_cmd_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [30:0] amount;
  } div_stat_t;

endpackage

@@ rtl/core/mfp_timediv.sv @@
// time datapath: ticks * tempo / division, restoring divider one bit per cycle
// depends on mfp_pkg
module mfp_timediv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mfp_pkg::div_cmd_t  cmd_i,
  input  logic               ack_i,
  output mfp_pkg::div_stat_t stat_o
);
  import mfp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DONE
  } state_e;

  state_e             state_q;
  logic [5:0]         cnt_q;
  logic [27:0]        a_q;
  logic [23:0]        b_q;
  logic [TpqW-1:0]    d_q;
  logic [ProdW-1:0]   quot_q;
  logic [TpqW-1:0]    rem_q;
  logic [TpqW:0]      rem_shift;
  logic [TpqW:0]      rem_diff;
  logic               take;

  assign rem_shift = {rem_q, quot_q[ProdW-1]};
  assign rem_diff  = rem_shift - {1'b0, d_q};
  assign take      = !rem_diff[TpqW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_i.start) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_DIV;
          cnt_q   <= 6'(ProdW - 1);
        end
        S_DIV: begin
          if (cnt_q == '0) begin
            state_q <= S_DONE;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        S_DONE: begin
          if (ack_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_i.start) begin
      a_q <= cmd_i.ticks;
      b_q <= cmd_i.tempo;
      d_q <= cmd_i.tpq;
    end
    if (state_q == S_MUL) begin
      quot_q <= a_q * b_q;
      rem_q  <= '0;
    end else if (state_q == S_DIV) begin
      quot_q <= {quot_q[ProdW-2:0], take};
      rem_q  <= take ? rem_diff[TpqW-1:0] : rem_shift[TpqW-1:0];
    end
  end

  assign stat_o.busy   = (state_q != S_IDLE);
  assign stat_o.done   = (state_q == S_DONE);
  assign stat_o.amount = (|quot_q[ProdW-1:31]) ? 31'h7FFFFFFF : quot_q[30:0];

  a_done_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> ($past(state_q) == S_DIV || $past(state_q) == S_DONE))
    else $error("divider done without finishing");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> $past(state_q) == S_IDLE && $past(cmd_i.start))
    else $error("multiply without start");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> cnt_q < 6'(ProdW))
    else $error("divider count out of range");

endmodule

@@ rtl/core/mfp_parser.sv @@
// parse controller: walks the file byte by byte and issues results and divide commands
// depends on mfp_pkg
module mfp_parser #(
  parameter int unsigned MAX_VLQ_BYTES = mfp_pkg::MaxVlqBytesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              file_start_i,
  output logic              res_valid_o,
  output mfp_pkg::result_t  res_o,
  output mfp_pkg::div_cmd_t div_o
);
  import mfp_pkg::*;

  localparam logic [2:0] VlqMax = 3'(MAX_VLQ_BYTES);

  typedef enum logic [4:0] {
    PH_HMAGIC, PH_HLEN, PH_HFMT, PH_HNTRK, PH_HDIV, PH_TMAGIC, PH_TLEN,
    PH_DELTA, PH_STATUS, PH_ARG1, PH_ARG2, PH_SYSARG, PH_SXLEN, PH_SXDATA,
    PH_MTYPE, PH_MLEN, PH_MDATA, PH_DONE, PH_HALT
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  bi_q, bi_d;
  logic [31:0] fs_q, fs_d;
  logic [27:0] vlq_q, vlq_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] tl_q, tl_d;
  logic [15:0] tpq_q, tpq_d;
  logic [23:0] tempo_q, tempo_d;
  logic [7:0]  rs_q, rs_d;
  logic [6:0]  arg_q, arg_d;
  logic [31:0] tlen_q, tlen_d;
  logic [31:0] seen_q, seen_d;
  logic [7:0]  mt_q, mt_d;
  logic [27:0] mrem_q, mrem_d;
  logic [23:0] tc_q, tc_d;

  logic [7:0]  b;
  logic        gdone;
  logic        first;
  logic [1:0]  vr;
  logic [3:0]  cls;

  function automatic logic is_chan(input logic [7:0] s);
    return s[7] && (s[7:4] != 4'hF);
  endfunction

  function automatic logic meta_known(input logic [7:0] t);
    return (t <= 8'h0A) || (t inside {8'h20, 8'h21, 8'h2F, 8'h51, 8'h54, 8'h58,
                                      8'h59, 8'h7F});
  endfunction

  always_comb begin
    phase_d = phase_q; bi_d = bi_q; fs_d = fs_q; vlq_d = vlq_q; fmt_d = fmt_q;
    tl_d = tl_q; tpq_d = tpq_q; tempo_d = tempo_q; rs_d = rs_q; arg_d = arg_q;
    tlen_d = tlen_q; seen_d = seen_q; mt_d = mt_q; mrem_d = mrem_q; tc_d = tc_q;
    res_valid_o = 1'b0;
    res_o = '0;
    div_o = '0;
    b = data_byte_i;
    gdone = 1'b0;
    first = 1'b0;
    vr = 2'd0;
    cls = '0;
    if (accept_i) begin
      if (file_start_i) begin
        phase_d = PH_HMAGIC; bi_d = '0; fs_d = '0; vlq_d = '0; fmt_d = '0;
        tl_d = '0; tpq_d = TpqReset; tempo_d = TempoReset; rs_d = '0; arg_d = '0;
        tlen_d = '0; seen_d = '0; mt_d = '0; mrem_d = '0; tc_d = '0;
      end
      if (phase_d inside {[PH_DELTA:PH_MDATA]}) begin
        seen_d = seen_d + 32'd1;
      end
      // shared field gather and vlq step
      if (phase_d inside {[PH_HMAGIC:PH_TLEN]}) begin
        first = (bi_d == '0);
        fs_d  = {fs_d[23:0], b};
        bi_d  = bi_d + 3'd1;
        if (phase_d inside {PH_HFMT, PH_HNTRK, PH_HDIV}) begin
          gdone = (bi_d >= 3'd2);
        end else begin
          gdone = (bi_d >= 3'd4);
        end
        if (gdone) begin
          bi_d = '0;
        end
      end
      if (phase_d inside {PH_DELTA, PH_SXLEN, PH_MLEN}) begin
        vlq_d = {vlq_d[20:0], b[6:0]};
        bi_d  = bi_d + 3'd1;
        if (!b[7]) begin
          vr = 2'd1;
        end else if (bi_d >= VlqMax) begin
          vr = 2'd2;
        end
      end
      cls = rs_d[7:4];
      case (phase_d)
        PH_HMAGIC: begin
          if (gdone) begin
            if (fs_d != MagicHdr) begin
              res_valid_o = 1'b1; res_o.kind = KIND_ERROR; res_o.error_code = ERR_HDR_MAGIC;
              phase_d = PH_HALT;
            end else begin
              phase_d = PH_HLEN;
            end
          end
        end
        PH_HLEN: begin
          if (gdone) begin
            if (fs_d != HdrLen) begin
              res_valid_o = 1'b1; res_o.kind = KIND_ERROR; res_o.error_code = ERR_HDR_LEN;
              phase_d = PH_HALT;
            end else begin
              phase_d = PH_HFMT;
            end
          end
        end
        PH_HFMT: begin
          if (gdone) begin
            fmt_d = fs_d[15:0];
            phase_d = PH_HNTRK;
          end
        end
        PH_HNTRK: begin
          if (gdone) begin
            tl_d = fs_d[15:0];
            phase_d = PH_HDIV;
          end
        end
        PH_HDIV: begin
          if (gdone) begin
            tpq_d = fs_d[15:0];
            if (tl_d == '0) begin
              res_valid_o = 1'b1; res_o.kind = KIND_FDONE;
              phase_d = PH_DONE;
            end else begin
              phase_d = PH_TMAGIC;
            end
          end
        end
        PH_TMAGIC: begin
          if (gdone) begin
            if (fs_d != MagicTrk) begin
              res_valid_o = 1'b1; res_o.kind = KIND_ERROR; res_o.error_code = ERR_TRK_MAGIC;
              phase_d = PH_HALT;
            end else begin
              phase_d = PH_TLEN;
            end
          end else if (first && fmt_d != 16'd2) begin
            res_valid_o = 1'b1; res_o.kind = KIND_TRST;
          end
        end
        PH_TLEN: begin
          if (gdone) begin
            tlen_d = fs_d; seen_d = '0;
            phase_d = PH_DELTA; vlq_d = '0; bi_d = '0;
          end
        end
        PH_DELTA: begin
          if (vr == 2'd2) begin
            res_valid_o = 1'b1; res_o.kind = KIND_ERROR; res_o.error_code = ERR_VLQ;
            phase_d = PH_HALT;
          end else if (vr == 2'd1) begin
            if (tpq_d[15] || tpq_d == '0) begin
              res_valid_o = 1'b1; res_o.kind = KIND_ERROR; res_o.error_code = ERR_DIVISION;
              phase_d = PH_HALT;
            end else begin
              // time advance comes later from the divider
              div_o.start = 1'b1; div_o.ticks = vlq_d;
              div_o.tempo = tempo_d; div_o.tpq = tpq_d;
              phase_d = PH_STATUS;
            end
          end
        end
        PH_STATUS: begin
          if (!b[7]) begin
            if (!is_chan(rs_d)) begin
              res_valid_o = 1'b1; res_o.kind = KIND_ERROR; res_o.error_code = ERR_NO_RS;
              phase_d = PH_HALT;
            end else begin
              arg_d = b[6:0];
              if (cls inside {4'hC, 4'hD}) begin
                phase_d = PH_DELTA; vlq_d = '0; bi_d = '0;
              end else begin
                phase_d = PH_ARG2;
              end
            end
          end else begin
            rs_d = b;
            if (is_chan(b)) begin
              phase_d = PH_ARG1;
            end else begin
              vlq_d = '0; bi_d = '0;
              case (b)
                8'hF0, 8'hF7: phase_d = PH_SXLEN;
                8'hF1: phase_d = PH_DELTA;
                8'hF2: begin phase_d = PH_SYSARG; bi_d = 3'd2; end
                8'hF3: begin phase_d = PH_SYSARG; bi_d = 3'd1; end
                8'hFF: phase_d = PH_MTYPE;
                default: begin
                  res_valid_o = 1'b1; res_o.kind = KIND_ERROR; res_o.error_code = ERR_SYS;
                  phase_d = PH_HALT;
                end
              endcase
            end
          end
        end
        PH_ARG1: begin
          if (b[7]) begin
            res_valid_o = 1'b1; res_o.kind = KIND_ERROR; res_o.error_code = ERR_ARG_BIT7;
            phase_d = PH_HALT;
          end else begin
            arg_d = b[6:0];
            if (cls inside {4'hC, 4'hD}) begin
              phase_d = PH_DELTA; vlq_d = '0; bi_d = '0;
            end else begin
              phase_d = PH_ARG2;
            end
          end
        end
        PH_ARG2: begin
          if (b[7]) begin
            res_valid_o = 1'b1; res_o.kind = KIND_ERROR; res_o.error_code = ERR_ARG_BIT7;
            phase_d = PH_HALT;
          end else begin
            phase_d = PH_DELTA; vlq_d = '0; bi_d = '0;
            if (cls inside {4'h8, 4'h9}) begin
              res_valid_o = 1'b1; res_o.kind = KIND_NOTE;
              res_o.channel = rs_d[3:0]; res_o.key = arg_d; res_o.velocity = b[6:0];
              res_o.note_on = (cls == 4'h9) && (b != 8'h00);
            end
          end
        end
        PH_SYSARG: begin
          if (b[7]) begin
            res_valid_o = 1'b1; res_o.kind = KIND_ERROR; res_o.error_code = ERR_ARG_BIT7;
            phase_d = PH_HALT;
          end else begin
            bi_d = bi_d - 3'd1;
            if (bi_d == '0) begin
              phase_d = PH_DELTA; vlq_d = '0;
            end
          end
        end
        PH_SXLEN: begin
          if (vr == 2'd2) begin
            res_valid_o = 1'b1; res_o.kind = KIND_ERROR; res_o.error_code = ERR_VLQ;
            phase_d = PH_HALT;
          end else if (vr == 2'd1) begin
            mrem_d = vlq_d;
            if (vlq_d == '0) begin
              phase_d = PH_DELTA; vlq_d = '0; bi_d = '0;
            end else begin
              phase_d = PH_SXDATA;
            end
          end
        end
        PH_SXDATA: begin
          mrem_d = mrem_d - 28'd1;
          if (mrem_d == '0) begin
            phase_d = PH_DELTA; vlq_d = '0; bi_d = '0;
          end
        end
        PH_MTYPE: begin
          mt_d = b; tc_d = '0; vlq_d = '0; bi_d = '0;
          phase_d = PH_MLEN;
        end
        PH_MLEN, PH_MDATA: begin
          if (phase_d == PH_MDATA) begin
            tc_d = {tc_d[15:0], b};
            mrem_d = mrem_d - 28'd1;
          end
          if (phase_d == PH_MLEN && vr == 2'd2) begin
            res_valid_o = 1'b1; res_o.kind = KIND_ERROR; res_o.error_code = ERR_VLQ;
            phase_d = PH_HALT;
          end else if (phase_d == PH_MLEN && vr != 2'd1) begin
            phase_d = PH_MLEN;
          end else begin
            if (phase_d == PH_MLEN) begin
              mrem_d = vlq_d;
            end
            if (mrem_d != '0) begin
              phase_d = PH_MDATA;
            end else if (!meta_known(mt_d)) begin
              res_valid_o = 1'b1; res_o.kind = KIND_ERROR; res_o.error_code = ERR_META;
              phase_d = PH_HALT;
            end else begin
              if (mt_d == MetaTempo && vlq_d == 28'd3) begin
                tempo_d = tc_d;
              end
              if (mt_d == MetaEot) begin
                if (seen_d != tlen_d) begin
                  res_valid_o = 1'b1; res_o.kind = KIND_ERROR;
                  res_o.error_code = ERR_TRK_LEN;
                  phase_d = PH_HALT;
                end else begin
                  tl_d = tl_d - 16'd1;
                  res_valid_o = 1'b1; res_o.kind = KIND_TDONE;
                  res_o.last_track = (tl_d == '0);
                  phase_d = (tl_d == '0) ? PH_DONE : PH_TMAGIC;
                  bi_d = '0; fs_d = '0;
                end
              end else begin
                phase_d = PH_DELTA; vlq_d = '0; bi_d = '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HMAGIC; bi_q <= '0; fs_q <= '0; vlq_q <= '0; fmt_q <= '0;
      tl_q <= '0; tpq_q <= TpqReset; tempo_q <= TempoReset; rs_q <= '0; arg_q <= '0;
      tlen_q <= '0; seen_q <= '0; mt_q <= '0; mrem_q <= '0; tc_q <= '0;
    end else begin
      phase_q <= phase_d; bi_q <= bi_d; fs_q <= fs_d; vlq_q <= vlq_d; fmt_q <= fmt_d;
      tl_q <= tl_d; tpq_q <= tpq_d; tempo_q <= tempo_d; rs_q <= rs_d; arg_q <= arg_d;
      tlen_q <= tlen_d; seen_q <= seen_d; mt_q <= mt_d; mrem_q <= mrem_d; tc_q <= tc_d;
    end
  end

  a_res_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o || div_o.start) |-> accept_i)
    else $error("parser output without a byte");
  a_one_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_valid_o && div_o.start))
    else $error("parser result and divide in one byte");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HALT && !(accept_i && file_start_i)) |=> phase_q == PH_HALT)
    else $error("left halt without file start");

endmodule

@@ rtl/core/midi_file_event_parser.sv @@
// top level of the midi file event parser: handshakes, output register, parser and divider
// depends on mfp_pkg, mfp_parser, mfp_timediv
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid_i/in_stall_o   | data_byte_i, file_start_i
//   out     | output    | out_valid_o/out_stall_i | kind_o .. last_track_o
//
// a byte that completes a delta time stalls the input until the time word is taken, while
// the one-bit-per-cycle divider works through the 52-bit product by the 16-bit division.
// a word waiting at the output is held while out_stall_i is high; input stalls then.
// reset is asynchronous, active low; file_start_i restarts parsing at any byte.
module midi_file_event_parser #(
  parameter int unsigned MAX_VLQ_BYTES = mfp_pkg::MaxVlqBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        file_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [3:0]  channel_o,
  output logic [6:0]  key_o,
  output logic [6:0]  velocity_o,
  output logic        note_on_o,
  output logic [30:0] time_amount_o,
  output logic [3:0]  error_code_o,
  output logic        last_track_o
);
  import mfp_pkg::*;

  logic      accept;
  logic      out_free;
  logic      par_valid;
  result_t   par_res;
  div_cmd_t  div_cmd;
  div_stat_t div_stat;
  logic      div_ack;
  result_t   time_res;
  result_t   out_q;
  logic      out_valid_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = div_stat.busy || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign div_ack    = div_stat.done && out_free;

  mfp_parser #(.MAX_VLQ_BYTES(MAX_VLQ_BYTES)) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .file_start_i (file_start_i),
    .res_valid_o  (par_valid),
    .res_o        (par_res),
    .div_o        (div_cmd)
  );

  mfp_timediv u_timediv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .ack_i  (div_ack),
    .stat_o (div_stat)
  );

  always_comb begin
    time_res             = '0;
    time_res.kind        = KIND_TIME;
    time_res.time_amount = div_stat.amount;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= par_valid || div_stat.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (div_stat.done) begin
        out_q <= time_res;
      end else if (par_valid) begin
        out_q <= par_res;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_q.kind;
  assign channel_o     = out_q.channel;
  assign key_o         = out_q.key;
  assign velocity_o    = out_q.velocity;
  assign note_on_o     = out_q.note_on;
  assign time_amount_o = out_q.time_amount;
  assign error_code_o  = out_q.error_code;
  assign last_track_o  = out_q.last_track;

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> in_stall_o)
    else $error("byte taken while divider busy");
  a_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_stat.done && par_valid))
    else $error("divider and parser results together");
  a_div_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(div_stat.busy) |-> $past(accept))
    else $error("divider started without a byte");

endmodule

@@ tb/sv/tb_midi_file_event_parser.sv @@
// testbench for midi_file_event_parser: streams whole midi files, broken ones among them,
// predicts every output word in a scoreboard class and checks the words as they come out
// depends on mfp_pkg and the midi_file_event_parser rtl
module tb_midi_file_event_parser;
  import mfp_pkg::*;

  typedef enum int {
    PH_HMAGIC, PH_HLEN, PH_HFMT, PH_HNTRK, PH_HDIV, PH_TMAGIC, PH_TLEN,
    PH_DELTA, PH_STATUS, PH_ARG1, PH_ARG2, PH_SYSARG, PH_SXLEN, PH_SXDATA,
    PH_MTYPE, PH_MLEN, PH_MDATA, PH_DONE, PH_HALT
  } phase_e;

  // ways of damaging a generated file
  typedef enum int {
    FL_NONE, FL_HDR_MAGIC, FL_HDR_LEN, FL_NO_TRACKS, FL_DIVISION, FL_TRK_MAGIC,
    FL_VLQ, FL_NO_RS, FL_ARG_BIT7, FL_SYS, FL_META, FL_TRK_LEN, FL_NOISE, FL_BIG_DELTA
  } flaw_e;

  class midi_scoreboard;
    result_t     pending[$];
    int          errors;
    phase_e      ph;
    int          idx;
    bit [31:0]   shift, tlen, seen;
    bit [27:0]   vlq, remain;
    bit [15:0]   fmt, tleft, tpq;
    bit [23:0]   tempo, cand;
    bit [7:0]    rs, mtype;
    bit [6:0]    arg1;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      ph = PH_HMAGIC; idx = 0; shift = 0; vlq = 0; fmt = 0; tleft = 0;
      tpq = TpqReset; tempo = TempoReset; rs = 0; arg1 = 0; tlen = 0; seen = 0;
      mtype = 0; remain = 0; cand = 0;
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function bit gather(bit [7:0] b, int n);
      shift = {shift[23:0], b};
      idx = (idx + 1) & 7;
      if (idx >= n) begin
        idx = 0;
        return 1;
      end
      return 0;
    endfunction

    // 0 more bytes, 1 complete, 2 too long
    function int vlq_step(bit [7:0] b);
      vlq = {vlq[20:0], b[6:0]};
      idx = (idx + 1) & 7;
      if (!b[7]) return 1;
      return (idx >= MaxVlqBytesDefault) ? 2 : 0;
    endfunction

    function void go_delta();
      ph = PH_DELTA; vlq = 0; idx = 0;
    endfunction

    function bit is_chan(bit [7:0] s);
      return s[7] && s[7:4] != 4'hF;
    endfunction

    function bit one_arg(bit [7:0] s);
      return s[7:4] == 4'hC || s[7:4] == 4'hD;
    endfunction

    function bit fail(output result_t r, input err_e c);
      ph = PH_HALT;
      r = '0;
      r.kind = KIND_ERROR;
      r.error_code = c;
      return 1;
    endfunction

    function bit finish_meta(output result_t r);
      bit known;
      r = '0;
      known = mtype <= 8'h0A || mtype == 8'h20 || mtype == 8'h21 || mtype == MetaEot ||
              mtype == MetaTempo || mtype == 8'h54 || mtype == 8'h58 || mtype == 8'h59 ||
              mtype == 8'h7F;
      if (!known) return fail(r, ERR_META);
      if (mtype == MetaTempo && vlq == 3) tempo = cand;
      if (mtype == MetaEot) begin
        if (seen != tlen) return fail(r, ERR_TRK_LEN);
        tleft = tleft - 16'd1;
        r.kind = KIND_TDONE;
        r.last_track = (tleft == 0);
        ph = (tleft == 0) ? PH_DONE : PH_TMAGIC;
        idx = 0;
        shift = 0;
        return 1;
      end
      go_delta();
      return 0;
    endfunction

    function bit step(bit [7:0] b, bit st, output result_t r);
      int v;
      bit first;
      bit [63:0] amt;
      r = '0;
      if (st) clear();
      if (ph >= PH_DELTA && ph <= PH_MDATA) seen++;
      case (ph)
        PH_HMAGIC: if (gather(b, 4)) begin
          if (shift != MagicHdr) return fail(r, ERR_HDR_MAGIC);
          ph = PH_HLEN;
        end
        PH_HLEN: if (gather(b, 4)) begin
          if (shift != HdrLen) return fail(r, ERR_HDR_LEN);
          ph = PH_HFMT;
        end
        PH_HFMT: if (gather(b, 2)) begin
          fmt = shift[15:0];
          ph = PH_HNTRK;
        end
        PH_HNTRK: if (gather(b, 2)) begin
          tleft = shift[15:0];
          ph = PH_HDIV;
        end
        PH_HDIV: if (gather(b, 2)) begin
          tpq = shift[15:0];
          if (tleft == 0) begin
            ph = PH_DONE;
            r.kind = KIND_FDONE;
            return 1;
          end
          ph = PH_TMAGIC;
        end
        PH_TMAGIC: begin
          first = (idx == 0);
          if (gather(b, 4)) begin
            if (shift != MagicTrk) return fail(r, ERR_TRK_MAGIC);
            ph = PH_TLEN;
            return 0;
          end
          // every track restarts the clock unless tracks are independent
          if (first && fmt != 2) begin
            r.kind = KIND_TRST;
            return 1;
          end
        end
        PH_TLEN: if (gather(b, 4)) begin
          tlen = shift;
          seen = 0;
          go_delta();
        end
        PH_DELTA: begin
          v = vlq_step(b);
          if (v == 2) return fail(r, ERR_VLQ);
          if (v == 1) begin
            if (tpq[15] || tpq == 0) return fail(r, ERR_DIVISION);
            amt = (64'(vlq) * 64'(tempo)) / 64'(tpq);
            if (amt > 64'h7FFF_FFFF) amt = 64'h7FFF_FFFF;
            ph = PH_STATUS;
            r.kind = KIND_TIME;
            r.time_amount = amt[30:0];
            return 1;
          end
        end
        PH_STATUS: begin
          if (!b[7]) begin
            if (!is_chan(rs)) return fail(r, ERR_NO_RS);
            arg1 = b[6:0];
            if (one_arg(rs)) go_delta();
            else ph = PH_ARG2;
            return 0;
          end
          rs = b;
          if (is_chan(b)) begin
            ph = PH_ARG1;
            return 0;
          end
          vlq = 0;
          idx = 0;
          case (b)
            8'hF0, 8'hF7: ph = PH_SXLEN;
            8'hF1: go_delta();
            8'hF2: begin ph = PH_SYSARG; idx = 2; end
            8'hF3: begin ph = PH_SYSARG; idx = 1; end
            8'hFF: ph = PH_MTYPE;
            default: return fail(r, ERR_SYS);
          endcase
        end
        PH_ARG1: begin
          if (b[7]) return fail(r, ERR_ARG_BIT7);
          arg1 = b[6:0];
          if (one_arg(rs)) go_delta();
          else ph = PH_ARG2;
        end
        PH_ARG2: begin
          if (b[7]) return fail(r, ERR_ARG_BIT7);
          go_delta();
          if (rs[7:4] == 4'h8 || rs[7:4] == 4'h9) begin
            r.kind = KIND_NOTE;
            r.channel = rs[3:0];
            r.key = arg1;
            r.velocity = b[6:0];
            r.note_on = (rs[7:4] == 4'h9 && b != 0);
            return 1;
          end
        end
        PH_SYSARG: begin
          if (b[7]) return fail(r, ERR_ARG_BIT7);
          idx = (idx - 1) & 7;
          if (idx == 0) go_delta();
        end
        PH_SXLEN: begin
          v = vlq_step(b);
          if (v == 2) return fail(r, ERR_VLQ);
          if (v == 1) begin
            remain = vlq;
            if (remain == 0) go_delta();
            else ph = PH_SXDATA;
          end
        end
        PH_SXDATA: begin
          remain = remain - 28'd1;
          if (remain == 0) go_delta();
        end
        PH_MTYPE: begin
          mtype = b; cand = 0; vlq = 0; idx = 0;
          ph = PH_MLEN;
        end
        PH_MLEN: begin
          v = vlq_step(b);
          if (v == 2) return fail(r, ERR_VLQ);
          if (v == 1) begin
            remain = vlq;
            if (remain == 0) return finish_meta(r);
            ph = PH_MDATA;
          end
        end
        PH_MDATA: begin
          cand = {cand[15:0], b};
          remain = remain - 28'd1;
          if (remain == 0) return finish_meta(r);
        end
        default: ;
      endcase
      return 0;
    endfunction

    function void note_byte(bit [7:0] b, bit st);
      result_t r;
      if (step(b, st, r)) pending.push_back(r);
    endfunction

    task cmp(string name, longint got, longint want);
      if (got != want) report($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task check_word(result_t got);
      result_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word of kind %0d", got.kind));
        return;
      end
      e = pending.pop_front();
      cmp("kind", got.kind, e.kind);
      cmp("channel", got.channel, e.channel);
      cmp("key", got.key, e.key);
      cmp("velocity", got.velocity, e.velocity);
      cmp("note_on", got.note_on, e.note_on);
      cmp("time_amount", got.time_amount, e.time_amount);
      cmp("error_code", got.error_code, e.error_code);
      cmp("last_track", got.last_track, e.last_track);
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        file_start_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  kind_o;
  logic [3:0]  channel_o;
  logic [6:0]  key_o;
  logic [6:0]  velocity_o;
  logic        note_on_o;
  logic [30:0] time_amount_o;
  logic [3:0]  error_code_o;
  logic        last_track_o;

  midi_file_event_parser DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .data_byte_i(data_byte_i), .file_start_i(file_start_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .kind_o(kind_o), .channel_o(channel_o), .key_o(key_o), .velocity_o(velocity_o),
    .note_on_o(note_on_o), .time_amount_o(time_amount_o),
    .error_code_o(error_code_o), .last_track_o(last_track_o)
  );

  midi_scoreboard sb = new();
  bit [8:0] stim[$];
  bit [7:0] trk[$];
  bit       quiet = 0;
  int       hold = 0;

  initial begin
    clk_i = 0;
    rst_ni = 0;
    in_valid_i = 0;
    data_byte_i = 0;
    file_start_i = 0;
    out_stall_i = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
  end

  always #10 clk_i = ~clk_i;

  // output side: check each word, then stall a random while before the next
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_word({kind_e'(kind_o), channel_o, key_o, velocity_o, note_on_o,
                     time_amount_o, err_e'(error_code_o), last_track_o});
      hold = quiet ? 0 : $urandom_range(0, 3);
      out_stall_i <= (hold != 0);
    end else if (hold > 0) begin
      hold--;
      out_stall_i <= (hold != 0);
    end
  end

  function void put(bit [7:0] b, bit st = 0);
    stim.push_back({st, b});
  endfunction

  function void put_vlq(int unsigned val, int n);
    for (int i = n - 1; i >= 0; i--)
      trk.push_back(8'(((val >> (7 * i)) & 32'h7F) | (i != 0 ? 32'h80 : 32'h00)));
  endfunction

  function void rand_delta();
    int n;
    n = $urandom_range(0, 3) == 0 ? $urandom_range(2, 4) : 1;
    put_vlq($urandom_range(0, (1 << (7 * n)) - 1), n);
  endfunction

  function void push_n(int n);
    for (int i = 0; i < n; i++) trk.push_back(8'($urandom_range(0, 255)));
  endfunction

  function void put_track(flaw_e flaw);
    int ne, inj, rs_args, t;
    bit [7:0] known_meta[$] = '{8'h00, 8'h01, 8'h03, 8'h05, 8'h0A, 8'h20, 8'h21,
                                8'h54, 8'h58, 8'h59, 8'h7F};
    bit [7:0] bad_sys[$] = '{8'hF4, 8'hF5, 8'hF6, 8'hF8, 8'hFA, 8'hFC, 8'hFE};
    bit [31:0] len;
    trk.delete();
    ne = $urandom_range(1, 6);
    inj = $urandom_range(0, ne - 1);
    rs_args = 0;
    for (int e = 0; e < ne; e++) begin
      if (e == inj && flaw == FL_VLQ) begin
        trk.push_back(8'h80); trk.push_back(8'h80); trk.push_back(8'h80);
        trk.push_back(8'h80); trk.push_back(8'h00);
        continue;
      end
      if (e == inj && flaw == FL_BIG_DELTA) begin
        put_vlq(28'hFFFFFFF, 4);
        trk.push_back(8'hF1);
        rs_args = 0;
        continue;
      end
      rand_delta();
      if (e == inj) begin
        case (flaw)
          FL_NO_RS: begin
            trk.push_back(8'hF1); rand_delta(); trk.push_back(8'($urandom_range(0, 127)));
          end
          FL_ARG_BIT7: begin
            trk.push_back(8'h90 | 8'($urandom_range(0, 15)));
            trk.push_back(8'($urandom_range(128, 255)));
          end
          FL_SYS: trk.push_back(bad_sys[$urandom_range(0, bad_sys.size() - 1)]);
          FL_META: begin
            trk.push_back(8'hFF); trk.push_back(8'h30 + 8'($urandom_range(0, 15)));
            trk.push_back(8'h01); push_n(1);
          end
          default: ;
        endcase
        if (flaw inside {FL_NO_RS, FL_ARG_BIT7, FL_SYS, FL_META}) continue;
      end
      t = $urandom_range(0, 9);
      if (t == 2 && rs_args == 0) t = 0;
      case (t)
        0, 1: begin
          trk.push_back((t == 0 ? 8'h90 : 8'h80) | 8'($urandom_range(0, 15)));
          trk.push_back(8'($urandom_range(0, 127)));
          trk.push_back($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom_range(0, 127)));
          rs_args = 2;
        end
        2: begin
          trk.push_back(8'($urandom_range(0, 127)));
          if (rs_args == 2) trk.push_back(8'($urandom_range(0, 127)));
        end
        3: begin
          trk.push_back(($urandom_range(0, 2) == 0 ? 8'hA0 : ($urandom_range(0, 1) ?
                         8'hB0 : 8'hE0)) | 8'($urandom_range(0, 15)));
          trk.push_back(8'($urandom_range(0, 127)));
          trk.push_back(8'($urandom_range(0, 127)));
          rs_args = 2;
        end
        4: begin
          trk.push_back(($urandom_range(0, 1) ? 8'hC0 : 8'hD0) | 8'($urandom_range(0, 15)));
          trk.push_back(8'($urandom_range(0, 127)));
          rs_args = 1;
        end
        5: begin
          trk.push_back($urandom_range(0, 1) ? 8'hF0 : 8'hF7);
          t = $urandom_range(0, 3);
          trk.push_back(8'(t));
          push_n(t);
          rs_args = 0;
        end
        6: begin
          trk.push_back(8'hF1);
          rs_args = 0;
        end
        7: begin
          t = $urandom_range(0, 1);
          trk.push_back(t ? 8'hF2 : 8'hF3);
          trk.push_back(8'($urandom_range(0, 127)));
          if (t) trk.push_back(8'($urandom_range(0, 127)));
          rs_args = 0;
        end
        8: begin
          t = $urandom_range(0, 3) == 0 ? $urandom_range(2, 4) : 3;
          trk.push_back(8'hFF); trk.push_back(MetaTempo); trk.push_back(8'(t));
          push_n(t);
          rs_args = 0;
        end
        default: begin
          t = $urandom_range(0, 3);
          trk.push_back(8'hFF);
          trk.push_back(known_meta[$urandom_range(0, known_meta.size() - 1)]);
          trk.push_back(8'(t));
          push_n(t);
          rs_args = 0;
        end
      endcase
    end
    trk.push_back(8'h00); trk.push_back(8'hFF); trk.push_back(MetaEot); trk.push_back(8'h00);
    len = trk.size() + (flaw == FL_TRK_LEN ? $urandom_range(1, 2) : 0);
    put(8'h4D); put(8'h54); put(flaw == FL_TRK_MAGIC ? 8'h52 : 8'h72); put(8'h6B);
    for (int i = 3; i >= 0; i--) put(len[8*i +: 8]);
    foreach (trk[i]) put(trk[i]);
  endfunction

  function void gen_file(flaw_e flaw);
    int ntrk, bad;
    bit [15:0] div;
    if (flaw == FL_NOISE) begin
      put(8'($urandom_range(0, 255)), 1);
      repeat (20) put(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      return;
    end
    put(8'h4D, 1); put(8'h54); put(8'h68); put(flaw == FL_HDR_MAGIC ? 8'h65 : 8'h64);
    put(8'h00); put(8'h00); put(8'h00); put(flaw == FL_HDR_LEN ? 8'h07 : 8'h06);
    put(8'h00); put(8'($urandom_range(0, 2)));
    ntrk = (flaw == FL_NO_TRACKS) ? 0 : $urandom_range(1, 3);
    put(8'h00); put(8'(ntrk));
    if (flaw == FL_DIVISION) div = $urandom_range(0, 1) ? 16'h0000 : 16'h8000 |
                                   16'($urandom_range(0, 16'h7FFF));
    else if ($urandom_range(0, 3) == 0) div = 16'($urandom_range(1, 16'h7FFF));
    else div = 16'($urandom_range(1, 960));
    put(div[15:8]); put(div[7:0]);
    bad = $urandom_range(0, ntrk > 0 ? ntrk - 1 : 0);
    for (int i = 0; i < ntrk; i++) put_track(i == bad ? flaw : FL_NONE);
    // trailing bytes after the end are to be ignored
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
  endfunction

  task automatic send(bit [8:0] w);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    data_byte_i <= w[7:0];
    file_start_i <= w[8];
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(w[7:0], w[8]);
  endtask

  initial begin
    int f;
    // one file of each kind in turn while fewer than 550 bytes are queued, then mostly clean files
    f = FL_NONE;
    while (stim.size() < 550) begin
      if (f <= FL_BIG_DELTA) gen_file(flaw_e'(f));
      else gen_file($urandom_range(0, 9) < 7 ? FL_NONE : flaw_e'($urandom_range(1, 13)));
      f++;
    end
    wait (rst_ni === 1'b1);
    repeat (2) @(posedge clk_i);
    foreach (stim[i]) begin
      quiet = ((i / 100) % 3) == 2;
      if (i == stim.size() / 2) begin
        in_valid_i <= 0;
        while (sb.pending.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      send(stim[i]);
    end
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("midi_file_event_parser: match");
    else $display("midi_file_event_parser: mismatch");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("midi_file_event_parser: mismatch");
    $finish;
  end

endmodule
